// ----- rtl/core/ncg_pkg.sv -----
package ncg_pkg;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned SAMPLE_W     = 4;
  localparam int unsigned LFSR_W       = 15;
  localparam int unsigned PERIOD_W     = 12;
  localparam int unsigned LENGTH_W     = 8;
  localparam int unsigned LFSR_SHORT_TAP = 6;
  localparam int unsigned LFSR_TOP_BIT   = 14;
  localparam logic [SAMPLE_W-1:0] ENV_FULL = 4'd15;
  localparam logic [LFSR_W-1:0]   LFSR_SEED = 15'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 3'd0,
    ACT_QUARTER   = 3'd1,
    ACT_HALF      = 3'd2,
    ACT_ENV_WR    = 3'd3,
    ACT_PERIOD_WR = 3'd4,
    ACT_LENGTH_WR = 3'd5,
    ACT_ENABLE_WR = 3'd6
  } action_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                length_active;
  } voice_out_t;

  function automatic logic [PERIOD_W-1:0] period_lookup(input logic pal,
                                                        input logic [3:0] idx);
    logic [PERIOD_W-1:0] p;
    p = '0;
    if (pal) begin
      unique case (idx)
        4'd0:  p = 12'd4;
        4'd1:  p = 12'd8;
        4'd2:  p = 12'd14;
        4'd3:  p = 12'd30;
        4'd4:  p = 12'd60;
        4'd5:  p = 12'd88;
        4'd6:  p = 12'd118;
        4'd7:  p = 12'd148;
        4'd8:  p = 12'd188;
        4'd9:  p = 12'd236;
        4'd10: p = 12'd354;
        4'd11: p = 12'd472;
        4'd12: p = 12'd708;
        4'd13: p = 12'd944;
        4'd14: p = 12'd1890;
        4'd15: p = 12'd3778;
        default: p = '0;
      endcase
    end else begin
      unique case (idx)
        4'd0:  p = 12'd4;
        4'd1:  p = 12'd8;
        4'd2:  p = 12'd16;
        4'd3:  p = 12'd32;
        4'd4:  p = 12'd64;
        4'd5:  p = 12'd96;
        4'd6:  p = 12'd128;
        4'd7:  p = 12'd160;
        4'd8:  p = 12'd202;
        4'd9:  p = 12'd254;
        4'd10: p = 12'd380;
        4'd11: p = 12'd508;
        4'd12: p = 12'd762;
        4'd13: p = 12'd1016;
        4'd14: p = 12'd2034;
        4'd15: p = 12'd4068;
        default: p = '0;
      endcase
    end
    return p;
  endfunction

  function automatic logic [LENGTH_W-1:0] length_lookup(input logic [4:0] idx);
    logic [LENGTH_W-1:0] l;
    l = '0;
    unique case (idx)
      5'd0:  l = 8'd10;
      5'd1:  l = 8'd254;
      5'd2:  l = 8'd20;
      5'd3:  l = 8'd2;
      5'd4:  l = 8'd40;
      5'd5:  l = 8'd4;
      5'd6:  l = 8'd80;
      5'd7:  l = 8'd6;
      5'd8:  l = 8'd160;
      5'd9:  l = 8'd8;
      5'd10: l = 8'd60;
      5'd11: l = 8'd10;
      5'd12: l = 8'd14;
      5'd13: l = 8'd12;
      5'd14: l = 8'd26;
      5'd15: l = 8'd14;
      5'd16: l = 8'd12;
      5'd17: l = 8'd16;
      5'd18: l = 8'd24;
      5'd19: l = 8'd18;
      5'd20: l = 8'd48;
      5'd21: l = 8'd20;
      5'd22: l = 8'd96;
      5'd23: l = 8'd22;
      5'd24: l = 8'd192;
      5'd25: l = 8'd24;
      5'd26: l = 8'd72;
      5'd27: l = 8'd26;
      5'd28: l = 8'd16;
      5'd29: l = 8'd28;
      5'd30: l = 8'd32;
      5'd31: l = 8'd30;
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/core/ncg_cfg.sv -----
module ncg_cfg
  import ncg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  pal_timing
);

  logic pal_timing_r;
  logic pal_timing_nxt;
  logic reg_hit;

  assign reg_hit = (paddr[CFG_ADDR_W-1] == 1'b0);
  assign pready  = 1'b1;

  always_comb begin
    pal_timing_nxt = pal_timing_r;
    if (psel && penable && pwrite && reg_hit) begin
      pal_timing_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_timing_r <= 1'b0;
    end else begin
      pal_timing_r <= pal_timing_nxt;
    end
  end

  assign prdata     = reg_hit ? {{(CFG_DATA_W-1){1'b0}}, pal_timing_r} : '0;
  assign pal_timing = pal_timing_r;

endmodule

// ----- rtl/core/ncg_voice.sv -----
module ncg_voice
  import ncg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [ACTION_W-1:0] action,
  input  logic [DATA_W-1:0] write_data,
  input  logic              pal_timing,
  output voice_out_t        result
);

  logic [LFSR_W-1:0]   shift_reg_r,       shift_reg_nxt;
  logic [PERIOD_W-1:0] period_timer_r,    period_timer_nxt;
  logic [PERIOD_W-1:0] period_reload_r,   period_reload_nxt;
  logic                short_mode_r,      short_mode_nxt;
  logic [LENGTH_W-1:0] length_count_r,    length_count_nxt;
  logic                halt_loop_r,       halt_loop_nxt;
  logic                constant_volume_r, constant_volume_nxt;
  logic [SAMPLE_W-1:0] volume_or_rate_r,  volume_or_rate_nxt;
  logic [SAMPLE_W-1:0] env_divider_r,     env_divider_nxt;
  logic [SAMPLE_W-1:0] env_decay_r,       env_decay_nxt;
  logic                env_restart_r,     env_restart_nxt;
  logic                channel_enabled_r, channel_enabled_nxt;
  logic [SAMPLE_W-1:0] level_out_r,       level_out_nxt;

  logic                fb;
  logic [LFSR_W-1:0]   lfsr_shifted;
  logic [SAMPLE_W-1:0] volume;

  assign fb = shift_reg_r[0] ^ (short_mode_r ? shift_reg_r[LFSR_SHORT_TAP] : shift_reg_r[1]);
  assign lfsr_shifted = {fb, shift_reg_r[LFSR_W-1:1]};
  assign volume = constant_volume_r ? volume_or_rate_r : env_decay_r;

  always_comb begin
    shift_reg_nxt       = shift_reg_r;
    period_timer_nxt    = period_timer_r;
    period_reload_nxt   = period_reload_r;
    short_mode_nxt      = short_mode_r;
    length_count_nxt    = length_count_r;
    halt_loop_nxt       = halt_loop_r;
    constant_volume_nxt = constant_volume_r;
    volume_or_rate_nxt  = volume_or_rate_r;
    env_divider_nxt     = env_divider_r;
    env_decay_nxt       = env_decay_r;
    env_restart_nxt     = env_restart_r;
    channel_enabled_nxt = channel_enabled_r;
    level_out_nxt       = level_out_r;
    if (fire) begin
      unique case (action)
        ACT_TICK: begin
          if (period_timer_r == '0) begin
            period_timer_nxt = period_reload_r;
            shift_reg_nxt    = lfsr_shifted;
            if (!lfsr_shifted[0] && (length_count_r != '0)) begin
              level_out_nxt = volume;
            end else begin
              level_out_nxt = '0;
            end
          end else begin
            period_timer_nxt = period_timer_r - 1'b1;
          end
        end
        ACT_QUARTER: begin
          if (env_restart_r) begin
            env_restart_nxt = 1'b0;
            env_decay_nxt   = ENV_FULL;
            env_divider_nxt = volume_or_rate_r;
          end else if (env_divider_r == '0) begin
            if (halt_loop_r && (env_decay_r == '0)) begin
              env_decay_nxt = ENV_FULL;
            end else if (env_decay_r != '0) begin
              env_decay_nxt = env_decay_r - 1'b1;
            end
            env_divider_nxt = volume_or_rate_r;
          end else begin
            env_divider_nxt = env_divider_r - 1'b1;
          end
        end
        ACT_HALF: begin
          if (!halt_loop_r && (length_count_r != '0)) begin
            length_count_nxt = length_count_r - 1'b1;
          end
        end
        ACT_ENV_WR: begin
          halt_loop_nxt       = write_data[5];
          constant_volume_nxt = write_data[4];
          volume_or_rate_nxt  = write_data[3:0];
        end
        ACT_PERIOD_WR: begin
          period_reload_nxt = period_lookup(pal_timing, write_data[3:0]);
          short_mode_nxt    = write_data[7];
        end
        ACT_LENGTH_WR: begin
          if (channel_enabled_r) begin
            length_count_nxt = length_lookup(write_data[7:3]);
          end
          env_restart_nxt = 1'b1;
        end
        ACT_ENABLE_WR: begin
          channel_enabled_nxt = write_data[3];
          if (!write_data[3]) begin
            length_count_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_reg_r       <= LFSR_SEED;
      period_timer_r    <= '0;
      period_reload_r   <= '0;
      short_mode_r      <= 1'b0;
      length_count_r    <= '0;
      halt_loop_r       <= 1'b0;
      constant_volume_r <= 1'b0;
      volume_or_rate_r  <= '0;
      env_divider_r     <= '0;
      env_decay_r       <= '0;
      env_restart_r     <= 1'b0;
      channel_enabled_r <= 1'b0;
      level_out_r       <= '0;
    end else begin
      shift_reg_r       <= shift_reg_nxt;
      period_timer_r    <= period_timer_nxt;
      period_reload_r   <= period_reload_nxt;
      short_mode_r      <= short_mode_nxt;
      length_count_r    <= length_count_nxt;
      halt_loop_r       <= halt_loop_nxt;
      constant_volume_r <= constant_volume_nxt;
      volume_or_rate_r  <= volume_or_rate_nxt;
      env_divider_r     <= env_divider_nxt;
      env_decay_r       <= env_decay_nxt;
      env_restart_r     <= env_restart_nxt;
      channel_enabled_r <= channel_enabled_nxt;
      level_out_r       <= level_out_nxt;
    end
  end

  assign result.sample        = level_out_nxt;
  assign result.length_active = (length_count_nxt != '0);

  // disabled voice never holds a length
  a_len_zero_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    !channel_enabled_r |-> (length_count_r == '0))
    else $error("length counter nonzero while disabled");

endmodule

// ----- rtl/core/noise_channel_generator.sv -----
// Noise voice with a 15-bit LFSR, period timer (NTSC or PAL table), envelope
// and length counter. Each input transaction is one event (tick, quarter
// frame, half frame or a register write) and produces exactly one output
// transaction carrying the sample level and the length-active status after
// that event. An input register feeds the update logic into the output
// register; one transaction per clock is sustained while out_ready holds.
// pal_timing is read at APB byte address 0 and should be written only
// while no events are in flight.
module noise_channel_generator
  import ncg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [DATA_W-1:0]     in_write_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample,
  output logic                  out_length_active
);

  logic                pal_timing;
  logic                stg_valid_r, stg_valid_nxt;
  logic [ACTION_W-1:0] stg_action_r;
  logic [DATA_W-1:0]   stg_data_r;
  logic                out_valid_r, out_valid_nxt;
  voice_out_t          out_data_r;
  voice_out_t          voice_res;
  logic                advance;
  logic                in_fire;

  ncg_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pal_timing (pal_timing)
  );

  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  ncg_voice u_voice (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .action     (stg_action_r),
    .write_data (stg_data_r),
    .pal_timing (pal_timing),
    .result     (voice_res)
  );

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
    end else if (advance) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_action_r <= in_action;
      stg_data_r   <= in_write_data;
    end
    if (advance) begin
      out_data_r <= voice_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = out_data_r.sample;
  assign out_length_active = out_data_r.length_active;

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !advance) |=> stg_valid_r)
    else $error("pending event dropped from input stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !advance) |-> !in_ready)
    else $error("input accepted over a stalled event");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed event produced no output");

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncg_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
  localparam int REG_PAL_TIMING = 0;
  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACTION_W-1:0]   in_action = '0;
  logic [DATA_W-1:0]     in_write_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample;
  logic                  out_length_active;

  noise_channel_generator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample        (out_sample),
    .out_length_active (out_length_active)
  );

  always #4 clk = ~clk;

  // voice model state
  logic            pal_cfg;
  logic [14:0]     lfsr_q;
  logic [11:0]     timer_q;
  logic [11:0]     reload_q;
  logic            short_q;
  logic [7:0]      len_q;
  logic            halt_q;
  logic            const_vol_q;
  logic [3:0]      vol_rate_q;
  logic [3:0]      env_div_q;
  logic [3:0]      env_decay_q;
  logic            env_restart_q;
  logic            enabled_q;
  logic [3:0]      level_q;

  bit [11:0] ntsc_period [16] = '{4, 8, 16, 32, 64, 96, 128, 160, 202, 254, 380, 508, 762,
                                  1016, 2034, 4068};
  bit [11:0] pal_period  [16] = '{4, 8, 14, 30, 60, 88, 118, 148, 188, 236, 354, 472, 708,
                                  944, 1890, 3778};
  bit [7:0]  length_load [32] = '{10, 254, 20, 2, 40, 4, 80, 6, 160, 8, 60, 10, 14, 12, 26,
                                  14, 12, 16, 24, 18, 48, 20, 96, 22, 192, 24, 72, 26, 16,
                                  28, 32, 30};

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [DATA_W-1:0]   data;
    bit                  fixed;
    voice_out_t          out;
  } event_row_t;

  event_row_t  directed_rows[$];
  voice_out_t  pending_samples[$];
  voice_out_t  want;
  int          errors = 0;
  int          events_sent = 0;
  int          samples_checked = 0;
  int          lfsr_shifts = 0;
  int          in_stalls = 0;
  int          hold_left = 0;
  int          hold_mark = 400;
  int          rx_mode = 0;
  int          rx_mode_left = 0;

  task automatic reset_voice();
    pal_cfg       = 1'b0;
    lfsr_q        = 15'd1;
    timer_q       = '0;
    reload_q      = '0;
    short_q       = 1'b0;
    len_q         = '0;
    halt_q        = 1'b0;
    const_vol_q   = 1'b0;
    vol_rate_q    = '0;
    env_div_q     = '0;
    env_decay_q   = '0;
    env_restart_q = 1'b0;
    enabled_q     = 1'b0;
    level_q       = '0;
  endtask

  task automatic advance_voice(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] d);
    logic fb;
    case (act)
      ACT_TICK: begin
        if (timer_q == 0) begin
          timer_q = reload_q;
          fb = lfsr_q[0] ^ (short_q ? lfsr_q[6] : lfsr_q[1]);
          lfsr_q = {fb, lfsr_q[14:1]};
          level_q = (!lfsr_q[0] && len_q != 0) ? (const_vol_q ? vol_rate_q : env_decay_q)
                                                : 4'd0;
          lfsr_shifts++;
        end else begin
          timer_q = timer_q - 1'b1;
        end
      end
      ACT_QUARTER: begin
        if (env_restart_q) begin
          env_restart_q = 1'b0;
          env_decay_q   = ENV_FULL;
          env_div_q     = vol_rate_q;
        end else if (env_div_q == 0) begin
          if (halt_q && env_decay_q == 0)
            env_decay_q = ENV_FULL;
          else if (env_decay_q != 0)
            env_decay_q = env_decay_q - 1'b1;
          env_div_q = vol_rate_q;
        end else begin
          env_div_q = env_div_q - 1'b1;
        end
      end
      ACT_HALF: begin
        if (!halt_q && len_q != 0)
          len_q = len_q - 1'b1;
      end
      ACT_ENV_WR: begin
        halt_q      = d[5];
        const_vol_q = d[4];
        vol_rate_q  = d[3:0];
      end
      ACT_PERIOD_WR: begin
        reload_q = pal_cfg ? pal_period[d[3:0]] : ntsc_period[d[3:0]];
        short_q  = d[7];
      end
      ACT_LENGTH_WR: begin
        if (enabled_q)
          len_q = length_load[d[7:3]];
        env_restart_q = 1'b1;
      end
      ACT_ENABLE_WR: begin
        enabled_q = d[3];
        if (!enabled_q)
          len_q = '0;
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic offer_event(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] d,
                             input bit fixed, input voice_out_t fixed_out);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_write_data <= d;
    @(posedge clk);
    while (!in_ready) begin
      in_stalls++;
      @(posedge clk);
    end
    advance_voice(act, d);
    if (fixed)
      pending_samples.push_back(fixed_out);
    else
      pending_samples.push_back({level_q, len_q != 0});
    events_sent++;
  endtask

  task automatic row(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] d,
                     input bit fixed = 1'b0, input logic [3:0] smp = '0, input logic la = 1'b0);
    event_row_t r;
    r.act   = act;
    r.data  = d;
    r.fixed = fixed;
    r.out   = {smp, la};
    directed_rows.push_back(r);
  endtask

  task automatic write_pal_timing(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(REG_PAL_TIMING * 4);
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pal_cfg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== v) begin
      errors++;
      $error("pal_timing readback: expected %0b, actual %0b", v, prdata[0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_samples();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int               burst;
    int               gap;
    int               r;
    logic [ACTION_W-1:0] a;
    logic [DATA_W-1:0]   d;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0 && i != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      r = $urandom_range(0, 99);
      d = DATA_W'($urandom_range(0, 255));
      if (r < 58) begin
        a = ACT_TICK;
      end else if (r < 68) begin
        a = ACT_QUARTER;
      end else if (r < 76) begin
        a = ACT_HALF;
      end else if (r < 83) begin
        a = ACT_ENV_WR;
      end else if (r < 89) begin
        a = ACT_PERIOD_WR;
        // short periods keep the LFSR moving
        if ($urandom_range(0, 3) != 0)
          d[3:0] = 4'($urandom_range(0, 3));
      end else if (r < 95) begin
        a = ACT_LENGTH_WR;
      end else if (r < 99) begin
        a = ACT_ENABLE_WR;
        d[3] = ($urandom_range(0, 5) != 0);
      end else begin
        a = ACT_UNUSED;
      end
      offer_event(a, d, 1'b0, '0);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // result side: check, then pick next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $error("unexpected output transaction: sample %0d length_active %0b",
               out_sample, out_length_active);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (out_sample !== want.sample) begin
          errors++;
          $error("sample: expected %0d, actual %0d", want.sample, out_sample);
        end
        if (out_length_active !== want.length_active) begin
          errors++;
          $error("length_active: expected %0b, actual %0b", want.length_active,
                 out_length_active);
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rst_n && samples_checked >= hold_mark) begin
      hold_mark += 900;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) > 2);
        default: out_ready <= (rx_mode_left % 3 == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    reset_voice();

    // after reset: first tick shifts the LFSR, level stays 0 with no length
    row(ACT_TICK,      8'h00, 1'b1, 4'd0, 1'b0);
    row(ACT_HALF,      8'h00, 1'b1, 4'd0, 1'b0);
    // length write while disabled loads no length but still restarts the envelope
    row(ACT_LENGTH_WR, 8'hFF, 1'b1, 4'd0, 1'b0);
    row(ACT_ENABLE_WR, 8'h08, 1'b1, 4'd0, 1'b0);
    row(ACT_LENGTH_WR, 8'h08, 1'b1, 4'd0, 1'b1);
    row(ACT_ENV_WR,    8'h1F, 1'b1, 4'd0, 1'b1);
    row(ACT_PERIOD_WR, 8'h80, 1'b1, 4'd0, 1'b1);
    for (int i = 0; i < 6; i++)
      row(ACT_TICK, 8'hFF);
    row(ACT_QUARTER,   8'h00);
    row(ACT_ENV_WR,    8'h20);
    row(ACT_QUARTER,   8'h00);
    row(ACT_HALF,      8'h00);
    row(ACT_UNUSED,    8'hAA);
    row(ACT_PERIOD_WR, 8'h4F);
    row(ACT_LENGTH_WR, 8'hF8);
    row(ACT_ENV_WR,    8'hC5);
    row(ACT_TICK,      8'h00);
    row(ACT_ENABLE_WR, 8'hF7);
    row(ACT_ENABLE_WR, 8'hFF);
    row(ACT_LENGTH_WR, 8'h18);
    row(ACT_HALF,      8'h00);
    row(ACT_HALF,      8'h00);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_event(directed_rows[i].act, directed_rows[i].data, directed_rows[i].fixed,
                  directed_rows[i].out);
    drain_samples();

    // period already loaded under NTSC keeps running after the switch
    write_pal_timing(1'b1);
    run_random(700);
    drain_samples();
    write_pal_timing(1'b0);
    run_random(700);
    drain_samples();
    write_pal_timing(1'b1);
    run_random(600);
    drain_samples();
    repeat (20) @(posedge clk);

    $display("run covered %0d events under NTSC and PAL timing, %0d samples compared,",
             events_sent, samples_checked);
    $display("%0d LFSR shifts and %0d cycles of input back-pressure", lfsr_shifts, in_stalls);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
